// ===== rtl/imcv_pkg.sv =====
// ----------------------------------------------------------------------------
// imcv_pkg: shared types and constants of the 3x3 convolution filter
// Holds the stream payloads, the register file view, register indexes and the
// work item that travels from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package imcv_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_SIZE  = 3'd2;
  localparam logic [2:0] REG_KROW_TOP     = 3'd3;
  localparam logic [2:0] REG_KROW_MID     = 3'd4;
  localparam logic [2:0] REG_KROW_BOT     = 3'd5;
  localparam logic [2:0] REG_DIVISOR      = 3'd6;

  localparam int CFG_DW   = 24;
  localparam int TAPS     = 9;
  localparam int ACC_W    = 21;
  localparam int MAG_W    = 20;
  localparam int DIV_STEPS = 20;

  // Kernel row and column of each flattened tap.
  localparam logic [1:0] TAP_ROW [TAPS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                            2'd2, 2'd2, 2'd2};
  localparam logic [1:0] TAP_COL [TAPS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                            2'd0, 2'd1, 2'd2};

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       is_pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  kernel_size;
    logic [23:0] kernel_row_top;
    logic [23:0] kernel_row_mid;
    logic [23:0] kernel_row_bot;
    logic [9:0]  divisor;
  } cfg_t;

  // One window ready for arithmetic: masked taps in kernel order.
  typedef struct packed {
    logic [TAPS-1:0][7:0] tap;
    logic                 eof;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/imcv_front.sv =====
// ----------------------------------------------------------------------------
// imcv_front: pixel intake, line stores and window assembly
// Reads the two line stores for each pixel, shifts the 3x3 window, masks the
// taps that fall outside the frame and hands the window to the queue.
// ----------------------------------------------------------------------------
module imcv_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  imcv_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  imcv_pkg::in_item_t  in_data,
  output logic                push,
  output imcv_pkg::job_t      job,
  input  imcv_pkg::q_status_t q_status
);
  import imcv_pkg::*;

  localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_LOAD = 2'b10
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic [IW-1:0]      col_r, col_nxt;
  logic [12:0]        row_r, row_nxt;
  logic [23:0]        cnt_r, cnt_nxt;
  logic [7:0]         px_r;
  logic [7:0]         up_r, lo_r;
  logic [2:0][2:0][7:0] win_r, win_nxt;

  logic [7:0]         upper_mem [MAX_WIDTH];
  logic [7:0]         lower_mem [MAX_WIDTH];

  logic [WW-1:0]      w_eff;
  logic [12:0]        h_eff;
  logic [1:0]         s_eff;
  logic               half;
  logic [23:0]        frame_px;
  logic               emit, eof, step;
  logic signed [14:0] oi, oj;
  logic [2:0]         row_ok, col_ok;

  // Effective register values.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = WW'(1);
    end else if ({21'b0, cfg.image_width} > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.image_width);
    end
    h_eff    = (cfg.image_height == '0) ? 13'd1 : cfg.image_height;
    s_eff    = (cfg.kernel_size == '0) ? 2'd1 : cfg.kernel_size;
    half     = (s_eff != 2'd1);
    frame_px = 24'(24'(w_eff) * 24'(h_eff));
  end

  assign in_stall = (state_r != F_IDLE);

  // Line store reads happen at accept; writes happen when the window steps.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      up_r <= upper_mem[col_r];
      lo_r <= lower_mem[col_r];
      px_r <= in_data.is_pad ? 8'd0 : in_data.pixel_in;
    end
    if (step) begin
      upper_mem[col_r] <= lo_r;
      lower_mem[col_r] <= px_r;
    end
  end

  // New window and output position.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = up_r;
    win_nxt[1][2] = lo_r;
    win_nxt[2][2] = px_r;

    emit = (row_r >= 13'd2) || (row_r == 13'd1 && col_r != '0);
    if (col_r != '0) begin
      oi = $signed({2'b0, row_r}) - 15'sd1;
      oj = $signed(15'(col_r)) - 15'sd1;
    end else begin
      oi = $signed({2'b0, row_r}) - 15'sd2;
      oj = $signed(15'(w_eff)) - 15'sd1;
    end
  end

  // Frame bounds per kernel row and column.
  always_comb begin
    logic signed [14:0] x, y;
    for (int k = 0; k < 3; k++) begin
      x = oi + 15'(k) - (half ? 15'sd1 : 15'sd0);
      y = oj + 15'(k) - (half ? 15'sd1 : 15'sd0);
      row_ok[k] = (k < 32'(s_eff)) && !x[14] && (x < $signed({2'b0, h_eff}));
      col_ok[k] = (k < 32'(s_eff)) && !y[14] && (y < $signed(15'(w_eff)));
    end
  end

  // Masked taps in kernel order.
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      if (row_ok[TAP_ROW[t]] && col_ok[TAP_COL[t]]) begin
        job.tap[t] = half ? win_nxt[TAP_ROW[t]][TAP_COL[t]] : win_nxt[1][1];
      end else begin
        job.tap[t] = 8'd0;
      end
    end
    job.eof = eof;
  end

  // Counters and sequencing.
  always_comb begin
    eof       = emit && ((cnt_r + 24'd1) >= frame_px);
    step      = (state_r == F_LOAD) && (!emit || !q_status.full);
    push      = step && emit;
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_LOAD;
      end
      F_LOAD: begin
        if (step) begin
          state_nxt = F_IDLE;
          if (({1'b0, col_r} + (IW+1)'(1)) >= (IW+1)'(w_eff)) begin
            col_nxt = '0;
            if (row_r != 13'h1FFF) row_nxt = row_r + 13'd1;
          end else begin
            col_nxt = col_r + IW'(1);
          end
          if (emit) cnt_nxt = cnt_r + 24'd1;
          if (eof) begin
            col_nxt = '0;
            row_nxt = '0;
            cnt_nxt = '0;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
      if (step) win_r <= win_nxt;
    end
  end

endmodule

// ===== rtl/imcv_queue.sv =====
// ----------------------------------------------------------------------------
// imcv_queue: two-entry window queue
// Decouples window assembly from the arithmetic so each side stalls on its own.
// ----------------------------------------------------------------------------
module imcv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  imcv_pkg::job_t      push_data,
  input  logic                pop,
  output imcv_pkg::job_t      pop_data,
  output imcv_pkg::q_status_t status
);
  import imcv_pkg::*;

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign pop_data     = mem_r[rptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/imcv_back.sv =====
// ----------------------------------------------------------------------------
// imcv_back: window arithmetic
// Accumulates the nine tap products with one shared multiplier, divides the
// sum by the divisor bit-serially (truncating toward zero) and holds the
// result until the output transaction completes.
// ----------------------------------------------------------------------------
module imcv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  imcv_pkg::cfg_t      cfg,
  input  imcv_pkg::q_status_t q_status,
  input  imcv_pkg::job_t      job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output imcv_pkg::out_item_t out_data
);
  import imcv_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t                 state_r;
  job_t                    job_r;
  logic [3:0]              tap_r;
  logic [4:0]              step_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    neg_r;
  logic [MAG_W-1:0]        num_r;
  logic [10:0]             rem_r;
  logic [7:0]              res_r;

  logic [23:0]             krow;
  logic signed [7:0]       coef;
  logic signed [16:0]      prod;
  logic [9:0]              dv;
  logic [10:0]             shifted;
  logic                    qbit;
  logic [MAG_W-1:0]        mag;

  // Coefficient of the current tap and its product.
  always_comb begin
    case (TAP_ROW[tap_r])
      2'd0:    krow = cfg.kernel_row_top;
      2'd1:    krow = cfg.kernel_row_mid;
      default: krow = cfg.kernel_row_bot;
    endcase
    coef = $signed(krow[8*TAP_COL[tap_r] +: 8]);
    prod = $signed({1'b0, job_r.tap[tap_r]}) * coef;
  end

  // One restoring division step.
  always_comb begin
    dv      = (cfg.divisor == '0) ? 10'd1 : cfg.divisor;
    shifted = {rem_r[9:0], num_r[MAG_W-1]};
    qbit    = (shifted >= {1'b0, dv});
    mag     = acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
  end

  assign pop       = (state_r == B_IDLE) && !q_status.empty;
  assign out_valid = (state_r == B_OUT);
  assign out_data.pixel_out    = res_r;
  assign out_data.end_of_frame = job_r.eof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!q_status.empty) state_r <= B_MAC;
        end
        B_MAC: begin
          if (tap_r == 4'(TAPS - 1)) state_r <= B_DIV;
        end
        B_DIV: begin
          if (step_r == 5'(DIV_STEPS)) state_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_stall) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r <= job;
        tap_r <= '0;
        acc_r <= '0;
      end
      B_MAC: begin
        acc_r  <= acc_r + {{(ACC_W-17){prod[16]}}, prod};
        tap_r  <= tap_r + 4'd1;
        step_r <= '0;
      end
      B_DIV: begin
        if (step_r == 5'd0) begin
          neg_r <= acc_r[ACC_W-1];
          num_r <= mag;
          rem_r <= '0;
        end else begin
          rem_r <= qbit ? (shifted - {1'b0, dv}) : shifted;
          num_r <= {num_r[MAG_W-2:0], qbit};
        end
        step_r <= step_r + 5'd1;
        // The last step's quotient bit joins the result directly.
        if (step_r == 5'(DIV_STEPS)) begin
          res_r <= neg_r ? (8'd0 - {num_r[6:0], qbit}) : {num_r[6:0], qbit};
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

endmodule

// ===== rtl/image_convolution_3x3.sv =====
// ----------------------------------------------------------------------------
// image_convolution_3x3: zero-padded 3x3 convolution over a pixel stream
// Top level: register file, window front end, queue and arithmetic back end.
// ----------------------------------------------------------------------------
// The front end reads the line stores as it accepts a pixel, then updates
// the window, and takes no new pixel until then; the update waits while the
// queue is full. Each window that yields a result then passes the back end:
// a load, nine taps on the shared multiplier, a setup step and twenty steps
// on the bit-serial divider, and an output step; it takes no new window
// until the result is accepted. Results trail the input by one row plus one
// pixel; send image_width+1 pad transactions after a frame to flush it. Line
// stores need no clearing pass after reset. Registers must be written only
// while the block is idle; the block itself does not enforce this.
module image_convolution_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  imcv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output imcv_pkg::out_item_t out_data
);
  import imcv_pkg::*;

  cfg_t      cfg_r;
  logic      push, pop;
  job_t      push_job, pop_job;
  q_status_t q_status;

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= 11'd1024;
      cfg_r.image_height   <= 13'd1024;
      cfg_r.kernel_size    <= 2'd3;
      cfg_r.kernel_row_top <= 24'd0;
      cfg_r.kernel_row_mid <= 24'd256;
      cfg_r.kernel_row_bot <= 24'd0;
      cfg_r.divisor        <= 10'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width    <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height   <= cfg_wdata[12:0];
        REG_KERNEL_SIZE:  cfg_r.kernel_size    <= cfg_wdata[1:0];
        REG_KROW_TOP:     cfg_r.kernel_row_top <= cfg_wdata;
        REG_KROW_MID:     cfg_r.kernel_row_mid <= cfg_wdata;
        REG_KROW_BOT:     cfg_r.kernel_row_bot <= cfg_wdata;
        REG_DIVISOR:      cfg_r.divisor        <= cfg_wdata[9:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  imcv_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .job      (push_job),
    .q_status (q_status)
  );

  imcv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .status    (q_status)
  );

  imcv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .job       (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The queue is never both full and empty.
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // A pop starts work, so no result is shown in the next cycle.
  a_pop_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !out_valid)
    else $error("result shown right after pop");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-padded 3x3 convolution filter: stream-level regression
// Drives pixel frames through the filter under random idle cycles and stalls
// on both sides. A built-in convolver predicts each filtered pixel, and every
// transaction on the result channel is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import imcv_pkg::*;

  localparam int LINE_MAX     = 1024;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int SETTLE_GAP   = 120;
  localparam int RANDOM_ITEMS = 620;

  typedef struct {
    logic [7:0] pixel;
    logic       pad;
    logic       typed;
    logic [7:0] want_pixel;
    logic       want_eof;
  } directed_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Shadow of the register file and of the filter state.
  int unsigned frame_width, frame_height, ksize, krow[3], div_reg;
  logic [7:0]  upper_line[LINE_MAX];
  logic [7:0]  lower_line[LINE_MAX];
  logic [7:0]  taps[3][3];
  int unsigned in_col, in_row, out_count;

  out_item_t   filtered_pixels[$];
  int          error_count;
  int unsigned cycle_count;
  int unsigned pixels_sent;
  bit          idling_on;

  image_convolution_3x3 uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed coefficient of kernel row r, column c.
  function automatic int kernel_coef(int unsigned r, int unsigned c);
    logic [23:0] packed_row;
    logic [7:0]  b;
    packed_row = krow[r][23:0];
    b = packed_row[8*c +: 8];
    return int'($signed(b));
  endfunction

  // Advance the convolver by one pixel; queue the filtered pixel if one is due.
  task automatic convolve_pixel(input logic [7:0] pixel, input logic pad);
    int unsigned w, hgt, s, hoff, col, row, idx, k, l;
    int          dv, oi, oj, x, y, sum, q;
    logic [7:0]  px, up, lo;
    logic        emit, eof;
    out_item_t   res;
    w   = (frame_width == 0) ? 1 : (frame_width > LINE_MAX ? LINE_MAX : frame_width);
    hgt = (frame_height == 0) ? 1 : frame_height;
    s   = (ksize == 0) ? 1 : ksize;
    dv  = (div_reg == 0) ? 1 : int'(div_reg);
    px  = pad ? 8'd0 : pixel;
    col = in_col;
    row = in_row;
    idx = (col < LINE_MAX) ? col : LINE_MAX - 1;
    up  = upper_line[idx];
    lo  = lower_line[idx];
    eof = 1'b0;
    upper_line[idx] = lo;
    lower_line[idx] = px;
    for (int r = 0; r < 3; r++) begin
      taps[r][0] = taps[r][1];
      taps[r][1] = taps[r][2];
    end
    taps[0][2] = up;
    taps[1][2] = lo;
    taps[2][2] = px;

    emit = (row >= 2) || (row == 1 && col >= 1);
    if (emit) begin
      sum  = 0;
      hoff = s / 2;
      if (col >= 1) begin
        oi = int'(row) - 1;
        oj = int'(col) - 1;
      end else begin
        oi = int'(row) - 2;
        oj = int'(w) - 1;
      end
      for (k = 0; k < s; k++) begin
        for (l = 0; l < s; l++) begin
          x = oi + int'(k) - int'(hoff);
          y = oj + int'(l) - int'(hoff);
          if (x >= 0 && x < int'(hgt) && y >= 0 && y < int'(w))
            sum += int'(taps[k + 1 - hoff][l + 1 - hoff]) * kernel_coef(k, l);
        end
      end
      q = sum / dv;
      out_count++;
      eof = (out_count >= w * hgt);
      res.pixel_out    = q[7:0];
      res.end_of_frame = eof;
      filtered_pixels.push_back(res);
    end

    if (col + 1 >= w) begin
      in_col = 0;
      if (in_row < 13'h1FFF) in_row++;
    end else begin
      in_col = col + 1;
    end
    if (eof) begin
      in_col = 0;
      in_row = 0;
      out_count = 0;
    end
  endtask

  // Register write; the shadow copy follows the same truncation.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  frame_width  = 32'(value[10:0]);
      REG_IMAGE_HEIGHT: frame_height = 32'(value[12:0]);
      REG_KERNEL_SIZE:  ksize        = 32'(value[1:0]);
      REG_KROW_TOP:     krow[0]      = 32'(value);
      REG_KROW_MID:     krow[1]      = 32'(value);
      REG_KROW_BOT:     krow[2]      = 32'(value);
      REG_DIVISOR:      div_reg      = 32'(value[9:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned w, input int unsigned h, input int unsigned s,
                           input logic [23:0] top, input logic [23:0] mid,
                           input logic [23:0] bot, input int unsigned dv);
    write_reg(REG_IMAGE_WIDTH, 24'(w));
    write_reg(REG_IMAGE_HEIGHT, 24'(h));
    write_reg(REG_KERNEL_SIZE, 24'(s));
    write_reg(REG_KROW_TOP, top);
    write_reg(REG_KROW_MID, mid);
    write_reg(REG_KROW_BOT, bot);
    write_reg(REG_DIVISOR, 24'(dv));
  endtask

  // Offer one pixel transaction and hold it until the filter takes it.
  task automatic send_pixel(input logic [7:0] pixel, input logic pad);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.pixel_in <= pixel;
    in_data.is_pad   <= pad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sender holds off until every predicted pixel has come back.
  task automatic drain();
    release_input();
    while (filtered_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // One whole frame plus its flush; noise puts pads inside and pixels in the flush.
  task automatic run_frame(input bit noisy);
    int unsigned w, h;
    logic        pad;
    w = (frame_width == 0) ? 1 : (frame_width > LINE_MAX ? LINE_MAX : frame_width);
    h = (frame_height == 0) ? 1 : frame_height;
    for (int unsigned i = 0; i < w * h; i++) begin
      pad = noisy && ($urandom_range(9) == 0);
      send_pixel(8'($urandom_range(255)), pad);
      convolve_pixel(in_data.pixel_in, pad);
    end
    for (int unsigned i = 0; i <= w; i++) begin
      pad = !(noisy && ($urandom_range(4) == 0));
      send_pixel(8'($urandom_range(255)), pad);
      convolve_pixel(in_data.pixel_in, pad);
    end
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < 36);
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_pixels.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d eof=%0b", $time,
                 out_data.pixel_out, out_data.end_of_frame);
        error_count++;
      end else begin
        want = filtered_pixels.pop_front();
        if (out_data.pixel_out !== want.pixel_out)
          begin
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   want.pixel_out, out_data.pixel_out);
          error_count++;
        end
        if (out_data.end_of_frame !== want.end_of_frame) begin
          $display("%0t: end_of_frame expected %0b actual %0b", $time,
                   want.end_of_frame, out_data.end_of_frame);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Two 2x2 frames with the identity kernel left from reset: plain extremes,
  // then a pad inside the frame and a pixel during the flush.
  directed_row_t directed_rows[14] = '{
    '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd1,   1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd255, 1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd128, 1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd1,   1'b1},
    '{8'd77,  1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd10,  1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd20,  1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd99,  1'b0, 1'b1, 8'd200, 1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd10,  1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd20,  1'b1}
  };

  initial begin
    out_item_t typed_res;
    int        frame_no;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    error_count = 0;
    cycle_count = 0;
    pixels_sent = 0;
    idling_on = 1'b1;
    frame_width = 1024; frame_height = 1024; ksize = 3;
    krow[0] = 0; krow[1] = 32'h000100; krow[2] = 0; div_reg = 1;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) taps[r][c] = '0;
    in_col = 0; in_row = 0; out_count = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    write_reg(REG_IMAGE_HEIGHT, 24'd2);
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].pixel, directed_rows[i].pad);
      convolve_pixel(directed_rows[i].pixel, directed_rows[i].pad);
      if (directed_rows[i].typed && filtered_pixels.size() != 0) begin
        typed_res.pixel_out    = directed_rows[i].want_pixel;
        typed_res.end_of_frame = directed_rows[i].want_eof;
        filtered_pixels[filtered_pixels.size() - 1] = typed_res;
      end
    end
    drain();

    // Extreme coefficients and the largest divisor on one long row.
    write_all(300, 1, 3, 24'h808080, 24'h7F7F7F, 24'h80FF01, 1023);
    run_frame(1'b1);
    drain();
    // Tall frame, one pixel wide; kernel size zero acts as one.
    write_all(1, 300, 0, 24'hFFFFFF, 24'h00FF80, 24'h7F0000, 1);
    run_frame(1'b0);
    drain();
    // Height and divisor written as zero.
    write_all(5, 0, 2, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 0);
    run_frame(1'b1);
    drain();

    // Random frames, with a stretch where neither side idles.
    pixels_sent = 0;
    frame_no = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      idling_on = !(frame_no >= 8 && frame_no < 20);
      write_all(($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                $urandom_range(0, 3),
                24'($urandom), 24'($urandom), 24'($urandom),
                ($urandom_range(19) == 0) ? 0 :
                (($urandom_range(2) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 16)));
      run_frame($urandom_range(3) == 0);
      drain();
      frame_no++;
    end
    idling_on = 1'b1;

    if (error_count == 0 && filtered_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
